@@ rtl/vna_pkg.sv @@
// Shared types and constants for the vertex normal accumulator.
// Used by vna_ctrl, vna_datapath and vertex_normal_accumulator; no dependencies.
`default_nettype none
package vna_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int COORD_W      = 24;
  localparam int EDGE_W       = COORD_W + 1;
  localparam int CROSS_W      = 2 * EDGE_W + 1;
  localparam int ACC_W        = 32;
  localparam int OUT_W        = 32;
  localparam int MUL_W        = 32;
  localparam int NORM_HI      = 31;  // normalized magnitudes lie in [2^30, 2^31)
  localparam int FRAC_W       = 16;
  localparam int QUO_W        = FRAC_W + 1;
  localparam int UNIT_W       = QUO_W + 1;
  localparam int REM_W        = NORM_HI + FRAC_W + 1;
  localparam int SQ_W         = 64;
  localparam int SQRT_STEPS   = SQ_W / 2;
  localparam int CROSS_STEPS  = 6;
  localparam int KIND_W       = 2;
  localparam int CNT_W        = 5;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FACE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  typedef enum logic [3:0] {
    DP_NOP, DP_CLEAR, DP_TAKE, DP_WR_VERT, DP_LD_VERT, DP_CROSS, DP_CHECK,
    DP_NORM, DP_SQUARE, DP_SQRT_INIT, DP_SQRT, DP_DIV_INIT, DP_DIV,
    DP_DIV_STORE, DP_NRM_WR, DP_OUT_LOAD
  } dp_op_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_WV, S_NRD, S_NOUT, S_FRD, S_FLD, S_CROSS, S_CHK,
    S_NORM, S_SQ, S_SQI, S_SQRT, S_DIVI, S_DIV, S_DST, S_URD, S_UWR
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e           op;
    logic [1:0]       sel;
    logic [CNT_W-1:0] cnt;
    logic             use_item;
    logic [IDX_W-1:0] clr_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic m_zero;
    logic norm_ok;
    logic can_load;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ rtl/vna_datapath.sv @@
// Datapath: vertex and normal stores, shared multiplier, shift normalizer,
// iterative square root and divider, saturating update. Depends on vna_pkg.
`default_nettype none
module vna_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire vna_pkg::dp_cmd_t                    cmd_i,
  output vna_pkg::dp_sts_t                         sts_o,
  input  wire logic [vna_pkg::IDX_W-1:0]           vertex_index_i,
  input  wire logic signed [vna_pkg::COORD_W-1:0]  coord_x_i,
  input  wire logic signed [vna_pkg::COORD_W-1:0]  coord_y_i,
  input  wire logic signed [vna_pkg::COORD_W-1:0]  coord_z_i,
  input  wire logic [vna_pkg::IDX_W-1:0]           corner_a_i,
  input  wire logic [vna_pkg::IDX_W-1:0]           corner_b_i,
  input  wire logic [vna_pkg::IDX_W-1:0]           corner_c_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [vna_pkg::OUT_W-1:0]         normal_x_o,
  output logic signed [vna_pkg::OUT_W-1:0]         normal_y_o,
  output logic signed [vna_pkg::OUT_W-1:0]         normal_z_o
);

  localparam int VW = 3 * vna_pkg::COORD_W;
  localparam int NW = 3 * vna_pkg::ACC_W;

  logic [VW-1:0] vmem [vna_pkg::MAX_VERTICES];
  logic [NW-1:0] nmem [vna_pkg::MAX_VERTICES];
  logic [VW-1:0] vrd_q;
  logic [NW-1:0] nrd_q;

  logic [vna_pkg::IDX_W-1:0] vidx_q;
  logic [vna_pkg::IDX_W-1:0] corner_q [3];
  logic signed [vna_pkg::COORD_W-1:0] pos_q [3];
  logic signed [vna_pkg::COORD_W-1:0] a_q [3];
  logic signed [vna_pkg::EDGE_W-1:0]  e1_q [3];
  logic signed [vna_pkg::EDGE_W-1:0]  e2_q [3];
  logic signed [vna_pkg::CROSS_W-1:0] c_q [3];
  logic [vna_pkg::SQ_W-1:0]  sum_q, sx_q, sr_q, sb_q;
  logic [vna_pkg::REM_W-1:0] rem_q, div_q;
  logic [vna_pkg::QUO_W-1:0] quo_q;
  logic                      neg_q;
  logic signed [vna_pkg::UNIT_W-1:0] n_q [3];
  logic out_valid_q;
  logic signed [vna_pkg::OUT_W-1:0] nx_q, ny_q, nz_q;

  logic [vna_pkg::IDX_W-1:0] corner_sel, nrd_addr;
  logic signed [vna_pkg::COORD_W-1:0] vrd [3];
  logic signed [vna_pkg::ACC_W-1:0]   nrd [3];
  logic signed [vna_pkg::ACC_W-1:0]   nupd [3];
  logic signed [vna_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*vna_pkg::MUL_W-1:0] prod;
  logic [vna_pkg::CROSS_W-1:0] mag [3];
  logic [vna_pkg::CROSS_W-1:0] mag_or;
  logic hi, lo;
  logic [vna_pkg::SQ_W-1:0] st;
  logic [vna_pkg::NORM_HI:0] len;

  assign corner_sel = corner_q[cmd_i.sel];
  assign nrd_addr   = cmd_i.use_item ? vidx_q : corner_sel;
  // root of up to three squares below 2^62 needs 32 bits
  assign len        = sr_q[vna_pkg::NORM_HI:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vrd[i] = vrd_q[VW-1-i*vna_pkg::COORD_W -: vna_pkg::COORD_W];
      nrd[i] = nrd_q[NW-1-i*vna_pkg::ACC_W -: vna_pkg::ACC_W];
      mag[i] = c_q[i][vna_pkg::CROSS_W-1] ? vna_pkg::CROSS_W'(-c_q[i])
                                          : vna_pkg::CROSS_W'(c_q[i]);
    end
    mag_or = mag[0] | mag[1] | mag[2];
    hi = |mag_or[vna_pkg::CROSS_W-1:vna_pkg::NORM_HI];
    lo = ~|mag_or[vna_pkg::CROSS_W-1:vna_pkg::NORM_HI-1];
  end

  // saturating add of the unit normal into the stored sum
  always_comb begin
    logic signed [vna_pkg::ACC_W:0] s;
    for (int i = 0; i < 3; i++) begin
      s = (vna_pkg::ACC_W+1)'(nrd[i]) + (vna_pkg::ACC_W+1)'(n_q[i]);
      if (s[vna_pkg::ACC_W] != s[vna_pkg::ACC_W-1])
        nupd[i] = s[vna_pkg::ACC_W] ? {1'b1, {(vna_pkg::ACC_W-1){1'b0}}}
                                    : {1'b0, {(vna_pkg::ACC_W-1){1'b1}}};
      else
        nupd[i] = s[vna_pkg::ACC_W-1:0];
    end
  end

  // shared multiplier: cross terms, then squares
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.op == vna_pkg::DP_CROSS) begin
      case (cmd_i.cnt[2:0])
        3'd0: begin mul_a = vna_pkg::MUL_W'(e1_q[1]); mul_b = vna_pkg::MUL_W'(e2_q[2]); end
        3'd1: begin mul_a = vna_pkg::MUL_W'(e1_q[2]); mul_b = vna_pkg::MUL_W'(e2_q[1]); end
        3'd2: begin mul_a = vna_pkg::MUL_W'(e1_q[2]); mul_b = vna_pkg::MUL_W'(e2_q[0]); end
        3'd3: begin mul_a = vna_pkg::MUL_W'(e1_q[0]); mul_b = vna_pkg::MUL_W'(e2_q[2]); end
        3'd4: begin mul_a = vna_pkg::MUL_W'(e1_q[0]); mul_b = vna_pkg::MUL_W'(e2_q[1]); end
        3'd5: begin mul_a = vna_pkg::MUL_W'(e1_q[1]); mul_b = vna_pkg::MUL_W'(e2_q[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (cmd_i.op == vna_pkg::DP_SQUARE) begin
      mul_a = c_q[cmd_i.cnt[1:0]][vna_pkg::MUL_W-1:0];
      mul_b = c_q[cmd_i.cnt[1:0]][vna_pkg::MUL_W-1:0];
    end
    prod = mul_a * mul_b;
    st   = sr_q + sb_q;
  end

  // stores, registered reads
  always_ff @(posedge clk_i) begin
    vrd_q <= vmem[corner_sel];
    nrd_q <= nmem[nrd_addr];
    if (cmd_i.op == vna_pkg::DP_WR_VERT) begin
      vmem[vidx_q] <= {pos_q[0], pos_q[1], pos_q[2]};
    end
    case (cmd_i.op)
      vna_pkg::DP_CLEAR:   nmem[cmd_i.clr_addr] <= '0;
      vna_pkg::DP_WR_VERT: nmem[vidx_q] <= '0;
      vna_pkg::DP_NRM_WR:  nmem[corner_sel] <= {nupd[0], nupd[1], nupd[2]};
      default: ;
    endcase
  end

  // arithmetic registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      vna_pkg::DP_TAKE: begin
        vidx_q      <= vertex_index_i;
        pos_q[0]    <= coord_x_i;
        pos_q[1]    <= coord_y_i;
        pos_q[2]    <= coord_z_i;
        corner_q[0] <= corner_a_i;
        corner_q[1] <= corner_b_i;
        corner_q[2] <= corner_c_i;
      end
      vna_pkg::DP_LD_VERT: begin
        for (int i = 0; i < 3; i++) begin
          case (cmd_i.sel)
            2'd0:    a_q[i]  <= vrd[i];
            2'd1:    e1_q[i] <= vna_pkg::EDGE_W'(vrd[i]) - vna_pkg::EDGE_W'(a_q[i]);
            default: e2_q[i] <= vna_pkg::EDGE_W'(vrd[i]) - vna_pkg::EDGE_W'(a_q[i]);
          endcase
          if (cmd_i.sel == 2'd2) c_q[i] <= '0;
        end
      end
      vna_pkg::DP_CROSS: begin
        if (cmd_i.cnt[0])
          c_q[cmd_i.cnt[2:1]] <= c_q[cmd_i.cnt[2:1]] - vna_pkg::CROSS_W'(prod);
        else
          c_q[cmd_i.cnt[2:1]] <= c_q[cmd_i.cnt[2:1]] + vna_pkg::CROSS_W'(prod);
      end
      vna_pkg::DP_CHECK: sum_q <= '0;
      vna_pkg::DP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (hi)      c_q[i] <= c_q[i] >>> 1;
          else if (lo) c_q[i] <= c_q[i] <<< 1;
        end
      end
      vna_pkg::DP_SQUARE: sum_q <= sum_q + vna_pkg::SQ_W'(prod);
      vna_pkg::DP_SQRT_INIT: begin
        sx_q <= sum_q;
        sr_q <= '0;
        sb_q <= vna_pkg::SQ_W'(1) << (vna_pkg::SQ_W - 2);
      end
      vna_pkg::DP_SQRT: begin
        if (sx_q >= st) begin
          sx_q <= sx_q - st;
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
      end
      vna_pkg::DP_DIV_INIT: begin
        rem_q <= vna_pkg::REM_W'({mag[cmd_i.sel][vna_pkg::NORM_HI-1:0],
                                  {vna_pkg::FRAC_W{1'b0}}})
               + vna_pkg::REM_W'(len >> 1);
        div_q <= vna_pkg::REM_W'({len, {vna_pkg::FRAC_W{1'b0}}});
        quo_q <= '0;
        neg_q <= c_q[cmd_i.sel][vna_pkg::CROSS_W-1];
      end
      vna_pkg::DP_DIV: begin
        if (rem_q >= div_q) begin
          rem_q <= rem_q - div_q;
          quo_q <= {quo_q[vna_pkg::QUO_W-2:0], 1'b1};
        end else begin
          quo_q <= {quo_q[vna_pkg::QUO_W-2:0], 1'b0};
        end
        div_q <= div_q >> 1;
      end
      vna_pkg::DP_DIV_STORE: begin
        n_q[cmd_i.sel] <= neg_q ? -vna_pkg::UNIT_W'(quo_q) : vna_pkg::UNIT_W'(quo_q);
      end
      vna_pkg::DP_OUT_LOAD: begin
        nx_q <= nrd[0];
        ny_q <= nrd[1];
        nz_q <= nrd[2];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == vna_pkg::DP_OUT_LOAD) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.m_zero   = (mag_or == '0);
  assign sts_o.norm_ok  = !hi && !lo;
  assign sts_o.can_load = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign normal_x_o     = nx_q;
  assign normal_y_o     = ny_q;
  assign normal_z_o     = nz_q;

  a_square_normalized: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == vna_pkg::DP_SQUARE |-> !hi)
    else $error("square taken before normalization finished");
  a_len_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == vna_pkg::DP_DIV_INIT |-> sr_q[vna_pkg::SQ_W-1:vna_pkg::NORM_HI+1] == '0)
    else $error("root wider than expected");
  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == vna_pkg::DP_DIV_STORE |-> quo_q <= (vna_pkg::QUO_W'(1) << vna_pkg::FRAC_W))
    else $error("unit component above one");

endmodule
`default_nettype wire

@@ rtl/vna_ctrl.sv @@
// Sequencer for the vertex normal accumulator: clearing pass, item decode,
// face normal steps and corner updates. Depends on vna_pkg.
`default_nettype none
module vna_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [vna_pkg::KIND_W-1:0]   kind_i,
  input  wire vna_pkg::dp_sts_t             sts_i,
  output vna_pkg::dp_cmd_t                  cmd_o
);

  vna_pkg::ctrl_state_e state_q, state_d;
  logic [1:0]                sel_q, sel_d;
  logic [vna_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [vna_pkg::IDX_W-1:0] clr_q;
  logic sel_last;

  assign sel_last = (sel_q == 2'd2);

  always_comb begin
    state_d = state_q;
    case (state_q)
      vna_pkg::S_CLEAR: if (&clr_q) state_d = vna_pkg::S_IDLE;
      vna_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            vna_pkg::KIND_WRITE: state_d = vna_pkg::S_WV;
            vna_pkg::KIND_FACE:  state_d = vna_pkg::S_FRD;
            vna_pkg::KIND_READ:  state_d = vna_pkg::S_NRD;
            default:             state_d = vna_pkg::S_IDLE;
          endcase
        end
      end
      vna_pkg::S_WV:    state_d = vna_pkg::S_IDLE;
      vna_pkg::S_NRD:   state_d = vna_pkg::S_NOUT;
      vna_pkg::S_NOUT:  if (sts_i.can_load) state_d = vna_pkg::S_IDLE;
      vna_pkg::S_FRD:   state_d = vna_pkg::S_FLD;
      vna_pkg::S_FLD:   state_d = sel_last ? vna_pkg::S_CROSS : vna_pkg::S_FRD;
      vna_pkg::S_CROSS:
        if (cnt_q == vna_pkg::CNT_W'(vna_pkg::CROSS_STEPS - 1)) state_d = vna_pkg::S_CHK;
      vna_pkg::S_CHK:   state_d = sts_i.m_zero ? vna_pkg::S_IDLE : vna_pkg::S_NORM;
      vna_pkg::S_NORM:  if (sts_i.norm_ok) state_d = vna_pkg::S_SQ;
      vna_pkg::S_SQ:    if (cnt_q == vna_pkg::CNT_W'(2)) state_d = vna_pkg::S_SQI;
      vna_pkg::S_SQI:   state_d = vna_pkg::S_SQRT;
      vna_pkg::S_SQRT:
        if (cnt_q == vna_pkg::CNT_W'(vna_pkg::SQRT_STEPS - 1)) state_d = vna_pkg::S_DIVI;
      vna_pkg::S_DIVI:  state_d = vna_pkg::S_DIV;
      vna_pkg::S_DIV:
        if (cnt_q == vna_pkg::CNT_W'(vna_pkg::QUO_W - 1)) state_d = vna_pkg::S_DST;
      vna_pkg::S_DST:   state_d = sel_last ? vna_pkg::S_URD : vna_pkg::S_DIVI;
      vna_pkg::S_URD:   state_d = vna_pkg::S_UWR;
      vna_pkg::S_UWR:   state_d = sel_last ? vna_pkg::S_IDLE : vna_pkg::S_URD;
      default:          state_d = vna_pkg::S_IDLE;
    endcase
  end

  // counters: corner select and step count
  always_comb begin
    sel_d = sel_q;
    cnt_d = cnt_q;
    case (state_q)
      vna_pkg::S_IDLE: begin
        sel_d = '0;
        cnt_d = '0;
      end
      vna_pkg::S_FLD, vna_pkg::S_DST, vna_pkg::S_UWR: sel_d = sel_last ? 2'd0 : sel_q + 2'd1;
      vna_pkg::S_CROSS, vna_pkg::S_SQ, vna_pkg::S_SQRT, vna_pkg::S_DIV:
        cnt_d = (state_d == state_q) ? cnt_q + vna_pkg::CNT_W'(1) : '0;
      default: ;
    endcase
  end

  always_comb begin
    cmd_o.op       = vna_pkg::DP_NOP;
    cmd_o.sel      = sel_q;
    cmd_o.cnt      = cnt_q;
    cmd_o.use_item = (state_q == vna_pkg::S_NRD) || (state_q == vna_pkg::S_NOUT);
    cmd_o.clr_addr = clr_q;
    in_stall_o     = (state_q != vna_pkg::S_IDLE);
    case (state_q)
      vna_pkg::S_CLEAR: cmd_o.op = vna_pkg::DP_CLEAR;
      vna_pkg::S_IDLE:  cmd_o.op = in_valid_i ? vna_pkg::DP_TAKE : vna_pkg::DP_NOP;
      vna_pkg::S_WV:    cmd_o.op = vna_pkg::DP_WR_VERT;
      vna_pkg::S_NOUT:  cmd_o.op = sts_i.can_load ? vna_pkg::DP_OUT_LOAD : vna_pkg::DP_NOP;
      vna_pkg::S_FLD:   cmd_o.op = vna_pkg::DP_LD_VERT;
      vna_pkg::S_CROSS: cmd_o.op = vna_pkg::DP_CROSS;
      vna_pkg::S_CHK:   cmd_o.op = vna_pkg::DP_CHECK;
      vna_pkg::S_NORM:  cmd_o.op = vna_pkg::DP_NORM;
      vna_pkg::S_SQ:    cmd_o.op = vna_pkg::DP_SQUARE;
      vna_pkg::S_SQI:   cmd_o.op = vna_pkg::DP_SQRT_INIT;
      vna_pkg::S_SQRT:  cmd_o.op = vna_pkg::DP_SQRT;
      vna_pkg::S_DIVI:  cmd_o.op = vna_pkg::DP_DIV_INIT;
      vna_pkg::S_DIV:   cmd_o.op = vna_pkg::DP_DIV;
      vna_pkg::S_DST:   cmd_o.op = vna_pkg::DP_DIV_STORE;
      vna_pkg::S_UWR:   cmd_o.op = vna_pkg::DP_NRM_WR;
      default:          cmd_o.op = vna_pkg::DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vna_pkg::S_CLEAR;
      sel_q   <= '0;
      cnt_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      cnt_q   <= cnt_d;
      if (state_q == vna_pkg::S_CLEAR) clr_q <= clr_q + vna_pkg::IDX_W'(1);
    end
  end

  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == vna_pkg::S_CLEAR |-> in_stall_o)
    else $error("item taken during clearing pass");
  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q != 2'd3)
    else $error("corner select out of range");
  a_face_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == vna_pkg::S_UWR && sel_last |=> state_q == vna_pkg::S_IDLE)
    else $error("face update did not return to idle");

endmodule
`default_nettype wire

@@ rtl/vertex_normal_accumulator.sv @@
// Top level of the vertex normal accumulator: ties the sequencer to the datapath.
// Depends on vna_pkg, vna_ctrl and vna_datapath.
`default_nettype none
// Keeps 1024 vertex positions (signed Q7.16) and 1024 normal sums (Q15.16,
// saturating at 32 bits). After reset a clearing pass zeroes the normal
// sums; no word is taken during it. A vertex write (kind 0) zeroes that
// vertex's sum. A read (kind 2) delivers one output word through an output
// register, so the next word can be taken while the result waits. A face
// (kind 1) runs through the corner reads, the cross product on the shared
// multiplier, the zero check, the normalizing shifts, the three squares, the
// bit-pair square root, the three restoring divisions into a unit vector and
// the read-modify-write of the three corner sums. A degenerate face adds
// nothing and skips the steps after the zero check. Kind 3 words are taken
// and dropped. A face that uses a vertex position never written gives an
// unspecified normal.
module vertex_normal_accumulator (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [vna_pkg::KIND_W-1:0]          kind_i,
  input  wire logic [vna_pkg::IDX_W-1:0]           vertex_index_i,
  input  wire logic signed [vna_pkg::COORD_W-1:0]  coord_x_i,
  input  wire logic signed [vna_pkg::COORD_W-1:0]  coord_y_i,
  input  wire logic signed [vna_pkg::COORD_W-1:0]  coord_z_i,
  input  wire logic [vna_pkg::IDX_W-1:0]           corner_a_i,
  input  wire logic [vna_pkg::IDX_W-1:0]           corner_b_i,
  input  wire logic [vna_pkg::IDX_W-1:0]           corner_c_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [vna_pkg::OUT_W-1:0]         normal_x_o,
  output logic signed [vna_pkg::OUT_W-1:0]         normal_y_o,
  output logic signed [vna_pkg::OUT_W-1:0]         normal_z_o
);

  vna_pkg::dp_cmd_t cmd;
  vna_pkg::dp_sts_t sts;

  // sequencer: owns the input handshake and all step counting
  vna_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: stores, arithmetic, output register
  vna_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .vertex_index_i (vertex_index_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .coord_z_i      (coord_z_i),
    .corner_a_i     (corner_a_i),
    .corner_b_i     (corner_b_i),
    .corner_c_i     (corner_c_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .normal_x_o     (normal_x_o),
    .normal_y_o     (normal_y_o),
    .normal_z_o     (normal_z_o)
  );

endmodule
`default_nettype wire

@@ dv/vertex_normal_accumulator_tb.sv @@
// Self-checking testbench for vertex_normal_accumulator: directed table, then random words.
// Depends on vna_pkg and the RTL of vertex_normal_accumulator; needs nothing else.
`timescale 1ns / 100ps
module vertex_normal_accumulator_tb;
  import vna_pkg::*;

  // one input word, field by field
  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [IDX_W-1:0]          vidx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [IDX_W-1:0]          a;
    logic [IDX_W-1:0]          b;
    logic [IDX_W-1:0]          c;
  } word_t;

  // directed row: word plus a flag for an all-zero normal known up front
  typedef struct packed {
    word_t w;
    bit    zero_exp;
  } row_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } normal_t;

  localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] CONE = 1;
  localparam logic signed [COORD_W-1:0] CZRO = 0;
  localparam logic signed [COORD_W-1:0] CNEG = -1;
  localparam logic [KIND_W-1:0]         KIND_NONE = 2'd3;  // unused kind, dropped

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [KIND_W-1:0]         kind_i = '0;
  logic [IDX_W-1:0]          vertex_index_i = '0;
  logic signed [COORD_W-1:0] coord_x_i = '0;
  logic signed [COORD_W-1:0] coord_y_i = '0;
  logic signed [COORD_W-1:0] coord_z_i = '0;
  logic [IDX_W-1:0]          corner_a_i = '0;
  logic [IDX_W-1:0]          corner_b_i = '0;
  logic [IDX_W-1:0]          corner_c_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [OUT_W-1:0]   normal_x_o;
  logic signed [OUT_W-1:0]   normal_y_o;
  logic signed [OUT_W-1:0]   normal_z_o;

  vertex_normal_accumulator i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .vertex_index_i,
    .coord_x_i, .coord_y_i, .coord_z_i, .corner_a_i, .corner_b_i, .corner_c_i,
    .out_valid_o, .out_stall_i, .normal_x_o, .normal_y_o, .normal_z_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the block: positions and normal sums
  longint  pos_mem [MAX_VERTICES][3];
  longint  sum_mem [MAX_VERTICES][3];
  bit      pos_valid [MAX_VERTICES];
  int      written_list[$];
  normal_t pending_normals[$];
  int      errors = 0;
  bit      quiet = 1'b0;   // no idling on either side while set

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // bit-pair integer square root, floor
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // unit face normal of (B-A) x (C-A), added to corners A, B, C in turn
  function automatic void add_face_normal(int ia, int ib, int ic);
    longint e1[3], e2[3], cr[3], n[3];
    longint unsigned m, sq, len, q;
    int k, idx[3];
    for (int i = 0; i < 3; i++) begin
      e1[i] = pos_mem[ib][i] - pos_mem[ia][i];
      e2[i] = pos_mem[ic][i] - pos_mem[ia][i];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    m = magnitude(cr[0]);
    if (magnitude(cr[1]) > m) m = magnitude(cr[1]);
    if (magnitude(cr[2]) > m) m = magnitude(cr[2]);
    if (m == 0) return;  // degenerate face
    k = 0;
    if (m >= (64'd1 << NORM_HI)) begin
      while ((m >> k) >= (64'd1 << NORM_HI)) k++;
      for (int i = 0; i < 3; i++) cr[i] = cr[i] >>> k;   // floor shift
    end else begin
      while ((m << k) < (64'd1 << (NORM_HI - 1))) k++;
      for (int i = 0; i < 3; i++) cr[i] = cr[i] <<< k;
    end
    sq = 0;
    for (int i = 0; i < 3; i++) sq += magnitude(cr[i]) * magnitude(cr[i]);
    len = root_floor(sq);
    if (len == 0) return;
    for (int i = 0; i < 3; i++) begin
      q = (magnitude(cr[i]) * 65536 + (len >> 1)) / len;
      n[i] = (cr[i] < 0) ? -longint'(q) : longint'(q);
    end
    idx[0] = ia; idx[1] = ib; idx[2] = ic;
    // repeated corners get one update per listing
    for (int j = 0; j < 3; j++)
      for (int i = 0; i < 3; i++)
        sum_mem[idx[j]][i] = sat32(sum_mem[idx[j]][i] + n[i]);
  endfunction

  // update the shadow for one accepted word; returns 1 with the normal on a read
  function automatic bit predict_normal(word_t w, output normal_t nrm);
    nrm = '0;
    case (w.kind)
      KIND_WRITE: begin
        pos_mem[w.vidx][0] = w.x;
        pos_mem[w.vidx][1] = w.y;
        pos_mem[w.vidx][2] = w.z;
        for (int i = 0; i < 3; i++) sum_mem[w.vidx][i] = 0;
        if (!pos_valid[w.vidx]) written_list.push_back(w.vidx);
        pos_valid[w.vidx] = 1'b1;
        return 1'b0;
      end
      KIND_FACE: begin
        add_face_normal(w.a, w.b, w.c);
        return 1'b0;
      end
      KIND_READ: begin
        nrm.x = sum_mem[w.vidx][0][OUT_W-1:0];
        nrm.y = sum_mem[w.vidx][1][OUT_W-1:0];
        nrm.z = sum_mem[w.vidx][2][OUT_W-1:0];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(word_t w, bit zero_exp);
    int      gap;
    normal_t nrm;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i         = w.kind;
    vertex_index_i = w.vidx;
    coord_x_i      = w.x;
    coord_y_i      = w.y;
    coord_z_i      = w.z;
    corner_a_i     = w.a;
    corner_b_i     = w.b;
    corner_c_i     = w.c;
    in_valid_i     = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (predict_normal(w, nrm)) pending_normals.push_back(zero_exp ? normal_t'('0) : nrm);
    @(negedge clk_i);
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return COORD_W'($urandom);
    if (r < 8) return COORD_W'($urandom_range(0, 8191)) - 4096;
    case ($urandom_range(0, 3))
      0: return CMAX;
      1: return CMIN;
      2: return CZRO;
      default: return CNEG;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    if ($urandom_range(0, 1) == 0) return IDX_W'($urandom_range(0, 31));
    return IDX_W'($urandom);
  endfunction

  // random word: faces use written corners only
  function automatic word_t rand_word();
    word_t w;
    int r;
    w = word_t'({$urandom, $urandom, $urandom, $urandom});
    r = $urandom_range(0, 99);
    if (r < 25 || (r < 70 && written_list.size() == 0)) begin
      w.kind = KIND_WRITE;
      w.vidx = rand_index();
      w.x = rand_coord();
      w.y = rand_coord();
      w.z = rand_coord();
    end else if (r < 70) begin
      w.kind = KIND_FACE;
      w.a = written_list[$urandom_range(0, written_list.size() - 1)];
      w.b = written_list[$urandom_range(0, written_list.size() - 1)];
      w.c = written_list[$urandom_range(0, written_list.size() - 1)];
    end else if (r < 95) begin
      w.kind = KIND_READ;
      w.vidx = rand_index();
    end else begin
      w.kind = KIND_NONE;
    end
    return w;
  endfunction

  // directed table: extremes, every kind, degenerate and repeated-corner faces
  localparam int N_DIR = 24;
  localparam row_t DIR_ROWS [N_DIR] = '{
    '{'{KIND_READ,  10'd5,    CZRO, CZRO, CZRO, 10'd0, 10'd0, 10'd0}, 1'b1},  // after reset
    '{'{KIND_WRITE, 10'd0,    CZRO, CZRO, CZRO, 10'd0, 10'd0, 10'd0}, 1'b0},
    '{'{KIND_WRITE, 10'd1,    CMAX, CZRO, CZRO, 10'd0, 10'd0, 10'd0}, 1'b0},
    '{'{KIND_WRITE, 10'd2,    CZRO, CMAX, CZRO, 10'd0, 10'd0, 10'd0}, 1'b0},
    '{'{KIND_FACE,  10'd0,    CZRO, CZRO, CZRO, 10'd0, 10'd1, 10'd2}, 1'b0},
    '{'{KIND_READ,  10'd0,    CZRO, CZRO, CZRO, 10'd0, 10'd0, 10'd0}, 1'b0},
    '{'{KIND_WRITE, 10'd3,    CMIN, CMIN, CMIN, 10'd0, 10'd0, 10'd0}, 1'b0},
    '{'{KIND_WRITE, 10'd4,    CMAX, CMAX, CMAX, 10'd0, 10'd0, 10'd0}, 1'b0},
    '{'{KIND_FACE,  10'd0,    CZRO, CZRO, CZRO, 10'd0, 10'd3, 10'd4}, 1'b0},  // collinear
    '{'{KIND_READ,  10'd3,    CZRO, CZRO, CZRO, 10'd0, 10'd0, 10'd0}, 1'b1},
    '{'{KIND_FACE,  10'd0,    CZRO, CZRO, CZRO, 10'd1, 10'd1, 10'd2}, 1'b0},  // repeated
    '{'{KIND_FACE,  10'd0,    CZRO, CZRO, CZRO, 10'd3, 10'd1, 10'd4}, 1'b0},  // huge cross
    '{'{KIND_WRITE, 10'd5,    CONE, CZRO, CZRO, 10'd0, 10'd0, 10'd0}, 1'b0},
    '{'{KIND_WRITE, 10'd6,    CZRO, CONE, CNEG, 10'd0, 10'd0, 10'd0}, 1'b0},
    '{'{KIND_FACE,  10'd0,    CZRO, CZRO, CZRO, 10'd0, 10'd5, 10'd6}, 1'b0},  // tiny cross
    '{'{KIND_READ,  10'd0,    CZRO, CZRO, CZRO, 10'd0, 10'd0, 10'd0}, 1'b0},
    '{'{KIND_READ,  10'd1,    CZRO, CZRO, CZRO, 10'd0, 10'd0, 10'd0}, 1'b0},
    '{'{KIND_READ,  10'd3,    CZRO, CZRO, CZRO, 10'd0, 10'd0, 10'd0}, 1'b0},
    '{'{KIND_READ,  10'd6,    CZRO, CZRO, CZRO, 10'd0, 10'd0, 10'd0}, 1'b0},
    '{'{KIND_NONE,  10'h3FF,  CNEG, CNEG, CNEG, 10'h3FF, 10'h3FF, 10'h3FF}, 1'b0},
    '{'{KIND_WRITE, 10'h3FF,  CNEG, CNEG, CNEG, 10'h3FF, 10'h3FF, 10'h3FF}, 1'b0},
    '{'{KIND_READ,  10'h3FF,  CZRO, CZRO, CZRO, 10'd0, 10'd0, 10'd0}, 1'b1},
    '{'{KIND_FACE,  10'd0,    CZRO, CZRO, CZRO, 10'h3FF, 10'd2, 10'd4}, 1'b0},
    '{'{KIND_READ,  10'h3FF,  CZRO, CZRO, CZRO, 10'd0, 10'd0, 10'd0}, 1'b0}
  };

  // receiver stall pattern, changed at falling edges
  initial begin
    int left;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (left > 0) begin
        left--;
      end else if (quiet || $urandom_range(0, 1) == 0) begin
        out_stall_i = 1'b0;
        left = $urandom_range(0, 6);
      end else begin
        out_stall_i = 1'b1;
        left = idle_len();
      end
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    normal_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_normals.size() == 0) begin
        $error("unexpected result word: %0d %0d %0d", normal_x_o, normal_y_o, normal_z_o);
        errors++;
      end else begin
        e = pending_normals.pop_front();
        if (normal_x_o !== e.x) begin
          $error("normal_x: expected %0d, got %0d", e.x, normal_x_o);
          errors++;
        end
        if (normal_y_o !== e.y) begin
          $error("normal_y: expected %0d, got %0d", e.y, normal_y_o);
          errors++;
        end
        if (normal_z_o !== e.z) begin
          $error("normal_z: expected %0d, got %0d", e.z, normal_z_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      pos_valid[i] = 1'b0;
      for (int j = 0; j < 3; j++) begin
        pos_mem[i][j] = 0;
        sum_mem[i][j] = 0;
      end
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIR_ROWS[i]) send_word(DIR_ROWS[i].w, DIR_ROWS[i].zero_exp);

    for (int n = 0; n < 1930; n++) begin
      if (n % 250 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (n == 1000) begin
        // sender holds off until the result side is drained
        in_valid_i = 1'b0;
        while (pending_normals.size() != 0) @(negedge clk_i);
      end
      send_word(rand_word(), 1'b0);
    end
    in_valid_i = 1'b0;

    while (pending_normals.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (errors == 0 && pending_normals.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
